// ----- hw/rtl/lcp_pkg.sv -----
package lcp_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int CW          = COORD_WIDTH;
  localparam int THR_W       = 32;

  // Exact widths of the intermediate terms.
  localparam int WW     = CW + 1;            // origin difference
  localparam int DOT_W  = 2 * WW + 1;        // sum of three products
  localparam int MW     = DOT_W;             // multiplier operand width
  localparam int PROD_W = 2 * MW;
  localparam int DET_W  = 2 * DOT_W + 1;     // determinant and numerators
  localparam int NUM_W  = DET_W + FRAC_BITS; // scaled divider numerator
  localparam int PW     = 2 * CW + 1;        // unscaled point sum

  localparam int LIMB_W = 32;
  localparam int LIMBS  = (MW + LIMB_W - 1) / LIMB_W;

  localparam int MUL_LAT = 5;
  localparam int DIV_LAT = CW + 2;

  // Pipeline positions, counted in cycles after the accepting edge.
  localparam int P1      = 1;
  localparam int P2      = P1 + MUL_LAT + 1;
  localparam int P3      = P2 + MUL_LAT + 1;
  localparam int P4      = P3 + 1;
  localparam int P5      = P4 + 1;
  localparam int PD      = P5 + DIV_LAT;
  localparam int P6      = PD + MUL_LAT + 1;
  localparam int TOT_LAT = P6 + 1;

  typedef enum logic [1:0] {
    ST_GENERAL  = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_DEGEN    = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0][CW-1:0] oa;
    logic [2:0][CW-1:0] u;
    logic [2:0][CW-1:0] ob;
    logic [2:0][CW-1:0] v;
  } geo_t;

endpackage

// ----- hw/rtl/lcp_mul.sv -----
module lcp_mul (
  input  logic                              clk,
  input  logic signed [lcp_pkg::MW-1:0]     a,
  input  logic signed [lcp_pkg::MW-1:0]     b,
  output logic signed [lcp_pkg::PROD_W-1:0] p
);
  import lcp_pkg::*;

  localparam int XW = LIMBS * LIMB_W;
  localparam int RW = XW + LIMB_W;

  logic [MW-1:0]         abs_a, abs_b;
  logic [XW-1:0]         ma_r, mb_r;
  logic [3:0]            neg_r;
  logic [2*LIMB_W-1:0]   pp_r [LIMBS][LIMBS];
  logic [RW-1:0]         row_r [LIMBS];
  logic [RW-1:0]         row_nxt [LIMBS];
  logic [2*XW-1:0]       sum_r, sum_nxt;
  logic signed [PROD_W-1:0] p_r;

  assign abs_a = a[MW-1] ? MW'(-a) : MW'(a);
  assign abs_b = b[MW-1] ? MW'(-b) : MW'(b);

  // Row i is |a| times limb i of |b|.
  always_comb begin
    for (int i = 0; i < LIMBS; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < LIMBS; j++) begin
        row_nxt[i] = row_nxt[i] + (RW'(pp_r[i][j]) << (LIMB_W * j));
      end
    end
    sum_nxt = '0;
    for (int i = 0; i < LIMBS; i++) begin
      sum_nxt = sum_nxt + ((2 * XW)'(row_r[i]) << (LIMB_W * i));
    end
  end

  always_ff @(posedge clk) begin
    ma_r  <= XW'(abs_a);
    mb_r  <= XW'(abs_b);
    neg_r <= {neg_r[2:0], a[MW-1] ^ b[MW-1]};
    for (int i = 0; i < LIMBS; i++) begin
      for (int j = 0; j < LIMBS; j++) begin
        pp_r[i][j] <= ma_r[j*LIMB_W +: LIMB_W] * mb_r[i*LIMB_W +: LIMB_W];
      end
      row_r[i] <= row_nxt[i];
    end
    sum_r <= sum_nxt;
    p_r   <= neg_r[3] ? PROD_W'(-sum_r) : PROD_W'(sum_r);
  end

  assign p = p_r;

endmodule

// ----- hw/rtl/lcp_div.sv -----
module lcp_div (
  input  logic                                   clk,
  input  logic signed [lcp_pkg::NUM_W-1:0]       num,
  input  logic signed [lcp_pkg::DET_W-1:0]       den,
  output logic signed [lcp_pkg::COORD_WIDTH-1:0] quo
);
  import lcp_pkg::*;

  localparam int RW = DET_W + CW;

  logic [NUM_W-1:0] abs_num;
  logic [DET_W-1:0] abs_den;
  logic [RW-1:0]    rem_r [0:CW-1];
  logic [DET_W-1:0] den_r [0:CW-1];
  logic [CW-1:0]    q_r   [1:CW];
  logic             neg_r [0:CW];
  logic             ovf_r [0:CW];
  logic [CW-1:0]    mag;
  logic             big;
  logic signed [CW-1:0] quo_nxt, quo_r;

  assign abs_num = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign abs_den = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);

  // A quotient of 2^CW or more saturates anyway, so only CW bits are developed.
  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(abs_num);
    den_r[0] <= abs_den;
    neg_r[0] <= num[NUM_W-1] ^ den[DET_W-1];
    ovf_r[0] <= RW'(abs_num) >= (RW'(abs_den) << CW);
  end

  for (genvar k = 0; k < CW; k++) begin : g_step
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(den_r[k]) << (CW - 1 - k);
    assign ge  = rem_r[k] >= dsh;

    always_ff @(posedge clk) begin
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end

    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        q_r[1] <= CW'(ge);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        q_r[k+1] <= {q_r[k][CW-2:0], ge};
      end
    end

    if (k < CW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[k+1] <= ge ? rem_r[k] - dsh : rem_r[k];
        den_r[k+1] <= den_r[k];
      end
    end
  end

  assign mag = q_r[CW];
  assign big = ovf_r[CW] || mag[CW-1];

  always_comb begin
    if (neg_r[CW]) begin
      quo_nxt = big ? {1'b1, {(CW-1){1'b0}}} : CW'(-mag);
    end else begin
      quo_nxt = big ? {1'b0, {(CW-1){1'b1}}} : mag;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;

endmodule

// ----- hw/rtl/line_closest_points_3d.sv -----
// Channel  Handshake               Payload
// input    start / busy            in_line_{a,b}_{origin,dir}_{x,y,z}
// result   out_strobe (one cycle)  out_param_s/t, out_point_{a,b}_{x,y,z}, out_status
// config   cfg_wr_en               cfg_wr_data (parallel threshold)
//
// One word is taken every cycle; busy is always low.
// Each result passes through 3 multiplier pipes of 5 stages, a 34-stage restoring
// divider that develops one quotient bit in each of its step stages, and 7 stages
// of add, compare and select.
// Synchronous reset clears the valid pipeline and sets the threshold to 1.
// The receiver cannot stall; results are never held back.
module line_closest_points_3d (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [lcp_pkg::COORD_WIDTH-1:0] in_line_a_origin_x,
  input  logic signed [lcp_pkg::COORD_WIDTH-1:0] in_line_a_origin_y,
  input  logic signed [lcp_pkg::COORD_WIDTH-1:0] in_line_a_origin_z,
  input  logic signed [lcp_pkg::COORD_WIDTH-1:0] in_line_a_dir_x,
  input  logic signed [lcp_pkg::COORD_WIDTH-1:0] in_line_a_dir_y,
  input  logic signed [lcp_pkg::COORD_WIDTH-1:0] in_line_a_dir_z,
  input  logic signed [lcp_pkg::COORD_WIDTH-1:0] in_line_b_origin_x,
  input  logic signed [lcp_pkg::COORD_WIDTH-1:0] in_line_b_origin_y,
  input  logic signed [lcp_pkg::COORD_WIDTH-1:0] in_line_b_origin_z,
  input  logic signed [lcp_pkg::COORD_WIDTH-1:0] in_line_b_dir_x,
  input  logic signed [lcp_pkg::COORD_WIDTH-1:0] in_line_b_dir_y,
  input  logic signed [lcp_pkg::COORD_WIDTH-1:0] in_line_b_dir_z,
  input  logic                                   cfg_wr_en,
  input  logic [lcp_pkg::THR_W-1:0]              cfg_wr_data,
  output logic                                   out_strobe,
  output logic signed [lcp_pkg::COORD_WIDTH-1:0] out_param_s,
  output logic signed [lcp_pkg::COORD_WIDTH-1:0] out_param_t,
  output logic signed [lcp_pkg::COORD_WIDTH-1:0] out_point_a_x,
  output logic signed [lcp_pkg::COORD_WIDTH-1:0] out_point_a_y,
  output logic signed [lcp_pkg::COORD_WIDTH-1:0] out_point_a_z,
  output logic signed [lcp_pkg::COORD_WIDTH-1:0] out_point_b_x,
  output logic signed [lcp_pkg::COORD_WIDTH-1:0] out_point_b_y,
  output logic signed [lcp_pkg::COORD_WIDTH-1:0] out_point_b_z,
  output logic [1:0]                             out_status
);
  import lcp_pkg::*;

  localparam int D_UW = 0;
  localparam int D_UU = 1;
  localparam int D_UV = 2;
  localparam int D_VW = 3;
  localparam int D_VV = 4;

  typedef struct packed {
    logic signed [DOT_W-1:0] uw;
    logic signed [DOT_W-1:0] uv;
    logic signed [DOT_W-1:0] vw;
  } dots3_t;

  function automatic logic signed [CW-1:0] shr_sat(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] y;
    logic                 hi_ovf, lo_ovf;
    // Truncate toward zero: bias negative values before the arithmetic shift.
    y = x[PW-1] ? (x + PW'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS : x >>> FRAC_BITS;
    hi_ovf = !y[PW-1] && (|y[PW-2:CW-1]);
    lo_ovf = y[PW-1] && !(&y[PW-2:CW-1]);
    if (hi_ovf) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (lo_ovf) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return y[CW-1:0];
  endfunction

  logic [THR_W-1:0] thr_r;
  logic             accept;
  logic             vld_r [1:TOT_LAT];
  geo_t             geo_nxt;
  geo_t             geo_r [1:P6-1];
  logic signed [WW-1:0] w_r [3];

  logic signed [MW-1:0]     m1a [5][3];
  logic signed [MW-1:0]     m1b [5][3];
  logic signed [PROD_W-1:0] m1p [5][3];
  logic signed [DOT_W-1:0]  dot_r [5];
  dots3_t                   dline_r [P2+1:P4];

  logic signed [MW-1:0]     m2a [6];
  logic signed [MW-1:0]     m2b [6];
  logic signed [PROD_W-1:0] m2p [6];

  logic signed [DET_W-1:0] det_r, nt_r, ns_r;
  logic signed [DET_W-1:0] det4_r, nt4_r, ns4_r;
  logic [DET_W-1:0]        adet_r;

  logic                    par;
  status_t                 stat_nxt;
  logic signed [NUM_W-1:0] num_s_nxt, num_t_nxt, num_s_r, num_t_r;
  logic signed [DET_W-1:0] den_nxt, den_r;
  status_t                 stat_r [P5:P6];

  logic signed [CW-1:0]     q_s, q_t;
  logic signed [CW-1:0]     s_line_r [PD+1:P6];
  logic signed [CW-1:0]     t_line_r [PD+1:P6];
  logic signed [MW-1:0]     pma [2][3];
  logic signed [MW-1:0]     pmb [2][3];
  logic signed [PROD_W-1:0] pmp [2][3];
  logic signed [PW-1:0]     pa_r [3];
  logic signed [PW-1:0]     pb_r [3];

  logic signed [CW-1:0] out_s_r, out_t_r;
  logic signed [CW-1:0] out_pa_r [3];
  logic signed [CW-1:0] out_pb_r [3];
  status_t              out_stat_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= TOT_LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[1] <= accept;
      for (int k = 2; k <= TOT_LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_comb begin
    geo_nxt.oa[0] = in_line_a_origin_x;
    geo_nxt.oa[1] = in_line_a_origin_y;
    geo_nxt.oa[2] = in_line_a_origin_z;
    geo_nxt.u[0]  = in_line_a_dir_x;
    geo_nxt.u[1]  = in_line_a_dir_y;
    geo_nxt.u[2]  = in_line_a_dir_z;
    geo_nxt.ob[0] = in_line_b_origin_x;
    geo_nxt.ob[1] = in_line_b_origin_y;
    geo_nxt.ob[2] = in_line_b_origin_z;
    geo_nxt.v[0]  = in_line_b_dir_x;
    geo_nxt.v[1]  = in_line_b_dir_y;
    geo_nxt.v[2]  = in_line_b_dir_z;
  end

  // Geometry travels alongside the arithmetic until the point sums.
  always_ff @(posedge clk) begin
    geo_r[1] <= geo_nxt;
    for (int k = 2; k <= P6 - 1; k++) begin
      geo_r[k] <= geo_r[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      w_r[i] <= WW'($signed(geo_nxt.oa[i])) - WW'($signed(geo_nxt.ob[i]));
    end
  end

  // Dot product terms.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m1a[D_UW][i] = MW'($signed(geo_r[P1].u[i]));
      m1b[D_UW][i] = MW'(w_r[i]);
      m1a[D_UU][i] = MW'($signed(geo_r[P1].u[i]));
      m1b[D_UU][i] = MW'($signed(geo_r[P1].u[i]));
      m1a[D_UV][i] = MW'($signed(geo_r[P1].u[i]));
      m1b[D_UV][i] = MW'($signed(geo_r[P1].v[i]));
      m1a[D_VW][i] = MW'($signed(geo_r[P1].v[i]));
      m1b[D_VW][i] = MW'(w_r[i]);
      m1a[D_VV][i] = MW'($signed(geo_r[P1].v[i]));
      m1b[D_VV][i] = MW'($signed(geo_r[P1].v[i]));
    end
  end

  for (genvar d = 0; d < 5; d++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_axis
      lcp_mul u_mul (
        .clk (clk),
        .a   (m1a[d][i]),
        .b   (m1b[d][i]),
        .p   (m1p[d][i])
      );
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < 5; d++) begin
      dot_r[d] <= DOT_W'(m1p[d][0]) + DOT_W'(m1p[d][1]) + DOT_W'(m1p[d][2]);
    end
    dline_r[P2+1] <= '{uw: dot_r[D_UW], uv: dot_r[D_UV], vw: dot_r[D_VW]};
    for (int k = P2 + 2; k <= P4; k++) begin
      dline_r[k] <= dline_r[k-1];
    end
  end

  // Products for the determinant and both numerators.
  always_comb begin
    m2a[0] = dot_r[D_UU]; m2b[0] = dot_r[D_VV];
    m2a[1] = dot_r[D_UV]; m2b[1] = dot_r[D_UV];
    m2a[2] = dot_r[D_UU]; m2b[2] = dot_r[D_VW];
    m2a[3] = dot_r[D_UW]; m2b[3] = dot_r[D_UV];
    m2a[4] = dot_r[D_UV]; m2b[4] = dot_r[D_VW];
    m2a[5] = dot_r[D_VV]; m2b[5] = dot_r[D_UW];
  end

  for (genvar m = 0; m < 6; m++) begin : g_m2
    lcp_mul u_mul (
      .clk (clk),
      .a   (m2a[m]),
      .b   (m2b[m]),
      .p   (m2p[m])
    );
  end

  always_ff @(posedge clk) begin
    det_r  <= DET_W'(m2p[0]) - DET_W'(m2p[1]);
    nt_r   <= DET_W'(m2p[2]) - DET_W'(m2p[3]);
    ns_r   <= DET_W'(m2p[4]) - DET_W'(m2p[5]);
    adet_r <= det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);
    det4_r <= det_r;
    nt4_r  <= nt_r;
    ns4_r  <= ns_r;
  end

  // Rule selection: near-singular systems fall back to the parallel rule.
  always_comb begin
    par = adet_r < DET_W'(thr_r);
    if (par) begin
      num_s_nxt = -(NUM_W'(dline_r[P4].vw) <<< FRAC_BITS);
      num_t_nxt = NUM_W'(dline_r[P4].uw) <<< FRAC_BITS;
      den_nxt   = DET_W'(dline_r[P4].uv);
      stat_nxt  = (dline_r[P4].uv == '0) ? ST_DEGEN : ST_PARALLEL;
    end else begin
      num_s_nxt = NUM_W'(ns4_r) <<< FRAC_BITS;
      num_t_nxt = NUM_W'(nt4_r) <<< FRAC_BITS;
      den_nxt   = det4_r;
      stat_nxt  = (det4_r == '0) ? ST_DEGEN : ST_GENERAL;
    end
  end

  always_ff @(posedge clk) begin
    num_s_r   <= num_s_nxt;
    num_t_r   <= num_t_nxt;
    den_r     <= den_nxt;
    stat_r[P5] <= stat_nxt;
    for (int k = P5 + 1; k <= P6; k++) begin
      stat_r[k] <= stat_r[k-1];
    end
  end

  lcp_div u_div_s (
    .clk (clk),
    .num (num_s_r),
    .den (den_r),
    .quo (q_s)
  );

  lcp_div u_div_t (
    .clk (clk),
    .num (num_t_r),
    .den (den_r),
    .quo (q_t)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pma[0][i] = MW'(q_s);
      pmb[0][i] = MW'($signed(geo_r[PD].u[i]));
      pma[1][i] = MW'(q_t);
      pmb[1][i] = MW'($signed(geo_r[PD].v[i]));
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_pt
    for (genvar i = 0; i < 3; i++) begin : g_axis
      lcp_mul u_mul (
        .clk (clk),
        .a   (pma[l][i]),
        .b   (pmb[l][i]),
        .p   (pmp[l][i])
      );
    end
  end

  always_ff @(posedge clk) begin
    s_line_r[PD+1] <= q_s;
    t_line_r[PD+1] <= q_t;
    for (int k = PD + 2; k <= P6; k++) begin
      s_line_r[k] <= s_line_r[k-1];
      t_line_r[k] <= t_line_r[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      pa_r[i] <= (PW'($signed(geo_r[P6-1].oa[i])) <<< FRAC_BITS) + PW'(pmp[0][i]);
      pb_r[i] <= (PW'($signed(geo_r[P6-1].ob[i])) <<< FRAC_BITS) + PW'(pmp[1][i]);
    end
  end

  // A zero divisor forces every numeric field to zero.
  always_ff @(posedge clk) begin
    out_stat_r <= stat_r[P6];
    if (stat_r[P6] == ST_DEGEN) begin
      out_s_r <= '0;
      out_t_r <= '0;
      for (int i = 0; i < 3; i++) begin
        out_pa_r[i] <= '0;
        out_pb_r[i] <= '0;
      end
    end else begin
      out_s_r <= s_line_r[P6];
      out_t_r <= t_line_r[P6];
      for (int i = 0; i < 3; i++) begin
        out_pa_r[i] <= shr_sat(pa_r[i]);
        out_pb_r[i] <= shr_sat(pb_r[i]);
      end
    end
  end

  assign out_strobe    = vld_r[TOT_LAT];
  assign out_param_s   = out_s_r;
  assign out_param_t   = out_t_r;
  assign out_point_a_x = out_pa_r[0];
  assign out_point_a_y = out_pa_r[1];
  assign out_point_a_z = out_pa_r[2];
  assign out_point_b_x = out_pb_r[0];
  assign out_point_b_y = out_pb_r[1];
  assign out_point_b_z = out_pb_r[2];
  assign out_status    = out_stat_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##TOT_LAT out_strobe)
    else $error("accepted word did not produce a result at the pipeline depth");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_DEGEN) |->
      (out_param_s == '0 && out_param_t == '0 && out_point_a_x == '0 &&
       out_point_a_y == '0 && out_point_a_z == '0 && out_point_b_x == '0 &&
       out_point_b_y == '0 && out_point_b_z == '0))
    else $error("degenerate result carries nonzero fields");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, TOT_LAT))
    else $error("result strobe without a word in flight behind it");
`endif

endmodule
